>>> hw/rtl/psg_pkg.sv
// Shared types, constants and the attenuation table of the sound generator.
// Used by psg_ctrl, psg_dp and psg_tone_noise_synth_core. No dependencies.
`default_nettype none

package psg_pkg;

	// Input clock of the emulated chip, in Hz (the phase stepping threshold)
	localparam logic [32:0] CHIP_CLOCK_HZ = 33'd3579545;

	localparam logic [16:0] SAMPLE_RATE_RESET = 17'd44100;
	localparam logic [14:0] NOISE_SEED        = 15'h4000;

	// Voice numbers with a special meaning
	localparam logic [1:0] TONE2_VOX  = 2'd2;
	localparam logic [1:0] NOISE_VOX  = 2'd3;
	// Noise rate code that follows the tone 2 period
	localparam logic [1:0] NOISE_SYNC = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       wr_byte;    // apply the command byte on data_byte
		logic       wr_period;  // recompute period and enable of the voice last written
		logic       sum_clr;    // start a new sample
		logic       load;       // load the working accumulator of voice vox
		logic       step;       // advance voice vox by one phase step
		logic       finish;     // store the accumulator and add the voice to the sum
		logic       out_load;   // move the sum into the output register
		logic [1:0] vox;        // voice being stepped
	} psg_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic below;     // working accumulator is still below the chip clock
		logic active;    // voice vox is enabled and has a nonzero period
		logic out_free;  // the output register can take a new item this cycle
	} psg_stat_t;

	// Attenuation: trunc(8191 * 10^(-i/10)), the last step mutes the voice
	function automatic logic [12:0] atten_level(input logic [3:0] code);
		logic [12:0] lvl;
		unique case (code)
			4'd0:    lvl = 13'd8191;
			4'd1:    lvl = 13'd6506;
			4'd2:    lvl = 13'd5168;
			4'd3:    lvl = 13'd4105;
			4'd4:    lvl = 13'd3260;
			4'd5:    lvl = 13'd2590;
			4'd6:    lvl = 13'd2057;
			4'd7:    lvl = 13'd1634;
			4'd8:    lvl = 13'd1298;
			4'd9:    lvl = 13'd1031;
			4'd10:   lvl = 13'd819;
			4'd11:   lvl = 13'd650;
			4'd12:   lvl = 13'd516;
			4'd13:   lvl = 13'd410;
			4'd14:   lvl = 13'd326;
			default: lvl = 13'd0;
		endcase
		return lvl;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/psg_tone_noise_synth_core.sv
// Top level of the tone and noise sound generator: controller plus datapath.
// Depends on psg_pkg, psg_ctrl and psg_dp.
//
// Usage:
//  - Input channel (in_valid / in_stall, fields func and data_byte): func = 0
//    carries one command byte (latch or data byte), func = 1 asks for one
//    output sample. An item is taken when in_valid is high and in_stall low.
//  - Output channel (out_valid / out_stall, field sample): one item per
//    sample request, none for a command byte. The sample is the sum of the
//    volumes of the enabled voices whose level is high.
//  - cfg_we / cfg_wdata write the output sample rate in Hz; it only affects
//    periods computed by later divider or noise mode writes.
// Timing:
//  - A command byte is decoded (ST_IDLE), then period multiply and enable (ST_WRP).
//  - A sample request loads each voice in turn, steps it if it is active and
//    finishes it, then moves the sum into the output register; the shared
//    phase stepper adds one period per cycle.
//  - One item is in work at a time; in_stall is high while it is.
// Reset: all voices silent and disabled, periods and phases zero, noise
//  register seeded to 0x4000, sample rate 44100. A stalled output holds its
//  sample; the next command byte is still taken, and the next sample waits.
`default_nettype none

module psg_tone_noise_synth_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [14:0]      sample
);
	import psg_pkg::*;

	psg_cmd_t  cmd;
	psg_stat_t stat;

	// Sequence writes and per-voice stepping
	psg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold voice state, step phases, build and hold the sample
	psg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.data_byte (data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sample    (sample)
	);

	a_no_double_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while the first is in work");

endmodule

`default_nettype wire

>>> hw/rtl/psg_ctrl.sv
// Controller of the sound generator: sequences command writes and sample ticks.
// Depends on psg_pkg; drives the datapath psg_dp through psg_cmd_t.
`default_nettype none

module psg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             func,
	output logic                  in_stall,
	input  wire psg_pkg::psg_stat_t stat,
	output psg_pkg::psg_cmd_t     cmd
);
	import psg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_WRP  = 6'b000010,
		ST_LOAD = 6'b000100,
		ST_STEP = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_DONE = 6'b100000
	} psg_state_t;

	psg_state_t state_q, state_nxt;
	logic [1:0] vox_q, vox_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		vox_nxt   = vox_q;
		cmd       = '0;
		cmd.vox   = vox_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!func) begin
						cmd.wr_byte = 1'b1;
						state_nxt   = ST_WRP;
					end else begin
						cmd.sum_clr = 1'b1;
						vox_nxt     = '0;
						state_nxt   = ST_LOAD;
					end
				end
			end
			ST_WRP: begin
				cmd.wr_period = 1'b1;
				state_nxt     = ST_IDLE;
			end
			ST_LOAD: begin
				cmd.load  = 1'b1;
				state_nxt = stat.active ? ST_STEP : ST_FIN;
			end
			ST_STEP: begin
				if (stat.below) begin
					cmd.step = 1'b1;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				if (vox_q == NOISE_VOX) begin
					state_nxt = ST_DONE;
				end else begin
					vox_nxt   = vox_q + 2'd1;
					state_nxt = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vox_q   <= '0;
		end else begin
			state_q <= state_nxt;
			vox_q   <= vox_nxt;
		end
	end

	a_write_then_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && !func) |=> (state_q == ST_WRP))
		else $error("command write not followed by period update");

	a_done_after_noise: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (vox_q == NOISE_VOX))
		else $error("sample finished before all voices were stepped");

endmodule

`default_nettype wire

>>> hw/rtl/psg_dp.sv
// Datapath of the sound generator: voice registers, shared phase stepper,
// noise shift register, sample sum and output register. Depends on psg_pkg.
`default_nettype none

module psg_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [16:0]      cfg_wdata,
	input  wire logic [7:0]       data_byte,
	input  wire psg_pkg::psg_cmd_t cmd,
	output psg_pkg::psg_stat_t    stat,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output logic [14:0]           sample
);
	import psg_pkg::*;

	logic [16:0] sample_rate_q;
	logic [2:0]  latched_q;
	logic [9:0]  div_q [3];
	logic [3:0]  mode_q;
	logic [12:0] vol_q [4];
	logic [31:0] per_q [4];
	logic [31:0] acc_q [4];
	logic [3:0]  en_q;
	logic [3:0]  lvl_q;
	logic [14:0] lfsr_q;
	logic [32:0] work_q;
	logic [14:0] sum_q;
	logic [14:0] sample_q;
	logic        out_valid_q;
	logic [1:0]  wv_q;
	logic        wk_tone_q;
	logic        wk_noise_q;

	// Command byte decode
	logic [2:0]  reg_sel;
	logic [1:0]  wr_v;
	logic        wr_tone, wr_noise;
	logic [9:0]  cur_div, tone_val;

	assign reg_sel  = data_byte[7] ? data_byte[6:4] : latched_q;
	assign wr_v     = reg_sel[2:1];
	assign wr_tone  = !reg_sel[0] && (wr_v != NOISE_VOX);
	assign wr_noise = !reg_sel[0] && (wr_v == NOISE_VOX);

	always_comb begin
		cur_div = '0;
		for (int i = 0; i < 3; i++) begin
			if (wr_v == 2'(i)) cur_div = div_q[i];
		end
	end

	// latch byte replaces the low nibble, data byte the upper six bits
	assign tone_val = data_byte[7] ? {cur_div[9:4], data_byte[3:0]}
	                               : {data_byte[5:0], cur_div[3:0]};

	// Period and enable of the voice last written
	logic [9:0]  pdiv;
	logic [26:0] prod;
	logic [31:0] tone_per, noise_per;
	logic        en_new;

	always_comb begin
		pdiv = '0;
		for (int i = 0; i < 3; i++) begin
			if (wv_q == 2'(i)) pdiv = div_q[i];
		end
	end

	assign prod     = 27'(pdiv) * 27'(sample_rate_q);
	assign tone_per = {1'b0, prod, 4'b0};

	always_comb begin
		unique case (mode_q[1:0])
			2'd0:    noise_per = {6'b0, sample_rate_q, 9'b0};
			2'd1:    noise_per = {5'b0, sample_rate_q, 10'b0};
			2'd2:    noise_per = {4'b0, sample_rate_q, 11'b0};
			default: noise_per = {per_q[TONE2_VOX][30:0], 1'b0};
		endcase
	end

	always_comb begin
		if (vol_q[wv_q] == '0) begin
			en_new = 1'b0;
		end else if (wv_q == NOISE_VOX) begin
			en_new = (mode_q[1:0] != NOISE_SYNC) || (div_q[TONE2_VOX] != '0);
		end else begin
			en_new = (pdiv != '0);
		end
	end

	// Noise shift: feedback into bit 14, white noise uses XNOR of the low two bits
	logic        fb;
	logic [14:0] lfsr_nxt;

	assign fb       = mode_q[2] ? ~(lfsr_q[0] ^ lfsr_q[1]) : lfsr_q[0];
	assign lfsr_nxt = {fb, lfsr_q[14:1]};

	assign stat.below    = (work_q < CHIP_CLOCK_HZ);
	assign stat.active   = en_q[cmd.vox] && (per_q[cmd.vox] != '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SAMPLE_RATE_RESET;
			latched_q     <= '0;
			mode_q        <= '0;
			en_q          <= '0;
			lvl_q         <= '0;
			lfsr_q        <= NOISE_SEED;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < 3; i++) div_q[i] <= '0;
			for (int i = 0; i < 4; i++) begin
				vol_q[i] <= '0;
				per_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			if (cfg_we) sample_rate_q <= cfg_wdata;

			if (cmd.wr_byte) begin
				if (data_byte[7]) latched_q <= data_byte[6:4];
				if (reg_sel[0]) begin
					vol_q[wr_v] <= atten_level(data_byte[3:0]);
				end else if (wr_tone) begin
					for (int i = 0; i < 3; i++) begin
						if (wr_v == 2'(i)) div_q[i] <= tone_val;
					end
				end else begin
					mode_q <= data_byte[3:0];
					lfsr_q <= NOISE_SEED;
				end
			end

			if (cmd.wr_period) begin
				if (wk_tone_q) begin
					for (int i = 0; i < 3; i++) begin
						if (wv_q == 2'(i)) per_q[i] <= tone_per;
					end
					// sync noise tracks tone 2 only when tone 2 changes
					if (wv_q == TONE2_VOX && mode_q[1:0] == NOISE_SYNC)
						per_q[NOISE_VOX] <= {prod, 5'b0};
				end
				if (wk_noise_q) per_q[NOISE_VOX] <= noise_per;
				en_q[wv_q] <= en_new;
			end

			if (cmd.step) begin
				if (cmd.vox == NOISE_VOX) begin
					lfsr_q           <= lfsr_nxt;
					lvl_q[NOISE_VOX] <= lfsr_q[1];
				end else begin
					lvl_q[cmd.vox] <= ~lvl_q[cmd.vox];
				end
			end

			if (cmd.finish && stat.active)
				acc_q[cmd.vox] <= 32'(work_q - CHIP_CLOCK_HZ);

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			wv_q       <= wr_v;
			wk_tone_q  <= wr_tone;
			wk_noise_q <= wr_noise;
		end
		if (cmd.load) begin
			work_q <= {1'b0, acc_q[cmd.vox]};
		end else if (cmd.step) begin
			work_q <= work_q + {1'b0, per_q[cmd.vox]};
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.finish && en_q[cmd.vox] && lvl_q[cmd.vox]) begin
			sum_q <= sum_q + 15'(vol_q[cmd.vox]);
		end
		if (cmd.out_load) sample_q <= sum_q;
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	a_step_below_clock: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (work_q < CHIP_CLOCK_HZ))
		else $error("phase step issued with accumulator past the chip clock");

	a_finish_past_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && stat.active) |-> (work_q >= CHIP_CLOCK_HZ))
		else $error("phase accumulator stored before reaching the chip clock");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for psg_tone_noise_synth_core: drives command bytes and sample requests.
// Depends on psg_pkg (seed, rate reset, voice numbers) and the core RTL.

module tb;
	import psg_pkg::*;

	// Item kinds on the func field
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// Register numbers carried in bits 6..4 of a latch byte
	localparam logic [2:0] REG_TONE0 = 3'd0;
	localparam logic [2:0] REG_ATT0  = 3'd1;
	localparam logic [2:0] REG_TONE1 = 3'd2;
	localparam logic [2:0] REG_ATT1  = 3'd3;
	localparam logic [2:0] REG_TONE2 = 3'd4;
	localparam logic [2:0] REG_ATT2  = 3'd5;
	localparam logic [2:0] REG_NOISE = 3'd6;
	localparam logic [2:0] REG_ATT3  = 3'd7;

	// Attenuation codes at both ends of the table
	localparam logic [3:0] ATT_LOUDEST = 4'h0;
	localparam logic [3:0] ATT_MUTE    = 4'hF;

	// Sample rates used across the run
	localparam logic [16:0] RATE_OFF  = 17'd0;
	localparam logic [16:0] RATE_MIN  = 17'd8000;
	localparam logic [16:0] RATE_MAX  = 17'd96000;
	localparam logic [16:0] RATE_FULL = 17'h1ffff;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        func      = FUNC_WRITE;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [14:0] sample;

	// Predicts every sample from the command bytes seen so far and holds the
	// samples still owed by the core, oldest first.
	class psg_scoreboard;
		logic [12:0] atten_tbl [16];
		logic [16:0] rate;
		logic [2:0]  latched;
		logic [9:0]  divider [3];
		logic [3:0]  nmode;
		logic [12:0] volume [4];
		logic [31:0] period [4];
		logic [31:0] phase [4];
		logic [3:0]  enabled;
		logic [3:0]  level;
		logic [14:0] lfsr;
		logic [14:0] expected_samples [$];
		int          n_errors;
		int          n_cmds;
		int          n_samples;

		function new();
			atten_tbl = '{13'd8191, 13'd6506, 13'd5168, 13'd4105, 13'd3260, 13'd2590,
				13'd2057, 13'd1634, 13'd1298, 13'd1031, 13'd819, 13'd650, 13'd516,
				13'd410, 13'd326, 13'd0};
			rate    = SAMPLE_RATE_RESET;
			latched = '0;
			nmode   = '0;
			enabled = '0;
			level   = '0;
			lfsr    = NOISE_SEED;
			foreach (divider[i])
				divider[i] = '0;
			foreach (volume[i]) begin
				volume[i] = '0;
				period[i] = '0;
				phase[i]  = '0;
			end
			n_errors  = 0;
			n_cmds    = 0;
			n_samples = 0;
		endfunction

		// Decode one command byte into divider, attenuation or noise mode,
		// then refresh the enable of the voice it touched.
		function void apply_command(logic [7:0] b);
			logic [2:0]  r;
			logic [1:0]  vx;
			logic [9:0]  val;
			logic [63:0] prod;
			val = {6'b0, b[3:0]};
			if (b[7]) begin
				r = b[6:4];
				latched = r;
				if (r != REG_NOISE && !r[0])
					val[9:4] = divider[r[2:1]][9:4];
			end else begin
				r = latched;
				if (r != REG_NOISE && !r[0])
					val = {b[5:0], divider[r[2:1]][3:0]};
			end
			vx = r[2:1];
			if (r[0]) begin
				volume[vx] = atten_tbl[val[3:0]];
			end else if (vx != NOISE_VOX) begin
				divider[vx] = val;
				prod = 64'(val) * 64'(rate);
				period[vx] = 32'(prod << 4);
				if (vx == TONE2_VOX && nmode[1:0] == NOISE_SYNC)
					period[NOISE_VOX] = period[TONE2_VOX] << 1;
			end else begin
				nmode = val[3:0];
				lfsr = NOISE_SEED;
				if (nmode[1:0] == NOISE_SYNC)
					period[NOISE_VOX] = period[TONE2_VOX] << 1;
				else
					period[NOISE_VOX] = {15'b0, rate} << (9 + nmode[1:0]);
			end
			if (volume[vx] == '0)
				enabled[vx] = 1'b0;
			else if (vx == NOISE_VOX)
				enabled[vx] = (nmode[1:0] != NOISE_SYNC) || (divider[TONE2_VOX] != '0);
			else
				enabled[vx] = (divider[vx] != '0);
			n_cmds++;
		endfunction

		// Advance every enabled voice past one chip-clock window and sum the
		// volumes of the voices left high.
		function logic [14:0] next_sample();
			logic [63:0] d;
			logic [63:0] p;
			logic [63:0] k;
			logic [63:0] clk_hz;
			logic [15:0] sum;
			logic        fb;
			clk_hz = 64'(CHIP_CLOCK_HZ);
			sum = '0;
			for (int i = 0; i < 4; i++) begin
				if (enabled[i]) begin
					d = 64'(phase[i]);
					p = 64'(period[i]);
					if (p != '0) begin
						if (i != NOISE_VOX) begin
							if (d < clk_hz) begin
								k = (clk_hz - d + p - 1) / p;
								d += k * p;
								if (k[0])
									level[i] = ~level[i];
							end
						end else begin
							while (d < clk_hz) begin
								fb = nmode[2] ? ~(lfsr[0] ^ lfsr[1]) : lfsr[0];
								lfsr = {fb, lfsr[14:1]};
								level[NOISE_VOX] = lfsr[0];
								d += p;
							end
						end
						phase[i] = 32'(d - clk_hz);
					end
					if (level[i])
						sum += 16'(volume[i]);
				end
			end
			n_samples++;
			return sum[14:0];
		endfunction

		function void note_item(logic f, logic [7:0] b);
			if (f == FUNC_TICK)
				expected_samples.push_back(next_sample());
			else
				apply_command(b);
		endfunction

		function void check_sample(logic [14:0] got);
			logic [14:0] want;
			if (expected_samples.size() == 0) begin
				n_errors++;
				$display("%0t ERROR: sample %0d arrived with none expected", $time, got);
			end else begin
				want = expected_samples.pop_front();
				if (got !== want) begin
					n_errors++;
					$display("%0t ERROR: sample expected %0d actual %0d", $time, want, got);
				end
			end
		endfunction
	endclass

	psg_scoreboard sb;

	int samples_seen    = 0;
	int rates_used      = 0;
	bit tight_input     = 1'b0;

	// Receiver side state: stall probability, time left in that mood, and
	// the long hold-off that backs the core up into its input.
	int stall_pct       = 30;
	int mood_left       = 0;
	int hold_left       = 0;
	int next_long_hold  = 100;

	psg_tone_noise_synth_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample the output channel on the rising edge; every accepted sample is
	// checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			samples_seen++;
			sb.check_sample(sample);
		end
	end

	// Drive out_stall on the falling edge. The stall rate changes mood now
	// and then (including a no-stall mood); a few times a long hold-off is
	// forced so the core holds a sample and stalls its input behind it.
	always @(negedge clk) begin
		if (mood_left == 0) begin
			mood_left = $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0:       stall_pct = 0;
				1:       stall_pct = 15;
				2:       stall_pct = 40;
				default: stall_pct = 75;
			endcase
		end else begin
			mood_left--;
		end
		if (hold_left == 0) begin
			if (samples_seen >= next_long_hold) begin
				hold_left = 400;
				next_long_hold += 700;
			end else if ($urandom_range(0, 199) == 0) begin
				hold_left = $urandom_range(20, 60);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic logic [7:0] latch_cmd(input logic [2:0] r, input logic [3:0] nib);
		return {1'b1, r, nib};
	endfunction

	function automatic logic [7:0] data_cmd(input logic hi, input logic [5:0] bits);
		return {1'b0, hi, bits};
	endfunction

	// Offer one item from a falling edge, after a random gap, and hold it
	// until the core takes it. Returns on the falling edge after acceptance
	// with valid still high, so back-to-back items need no extra edge.
	task automatic send_item(input logic f, input logic [7:0] b);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (tight_input || r < 45)
			gap = 0;
		else if (r < 88)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		data_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_item(f, b);
		@(negedge clk);
	endtask

	// Drop valid and wait out every owed sample, then give a command byte
	// that may still be in decode time to settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_samples.size() != 0)
			@(negedge clk);
		repeat (32) @(negedge clk);
	endtask

	task automatic set_rate(input logic [16:0] r);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.rate = r;
		rates_used++;
	endtask

	// Mostly well-formed programming: tone latch plus data byte, attenuation,
	// noise mode, bare data bytes to the latched register and runs of sample
	// requests; a small share is fully random noise on both fields.
	task automatic random_mix(input int n_items);
		int          sent;
		int          pick;
		int          reps;
		logic [1:0]  vx;
		logic [3:0]  nib;
		logic [5:0]  hi_bits;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 39) == 0)
				tight_input = ~tight_input;
			pick = $urandom_range(0, 99);
			if (pick < 28) begin
				vx = 2'($urandom_range(0, 2));
				send_item(FUNC_WRITE, latch_cmd({vx, 1'b0}, 4'($urandom)));
				sent++;
				if ($urandom_range(0, 99) < 85) begin
					// keep most dividers small so the levels move from sample to sample
					hi_bits = ($urandom_range(0, 99) < 60) ? 6'd0 : 6'($urandom);
					send_item(FUNC_WRITE, data_cmd(1'($urandom), hi_bits));
					sent++;
				end
			end else if (pick < 48) begin
				vx = 2'($urandom_range(0, 3));
				nib = ($urandom_range(0, 7) == 0) ? ATT_MUTE : 4'($urandom_range(0, 14));
				send_item(FUNC_WRITE, latch_cmd({vx, 1'b1}, nib));
				sent++;
			end else if (pick < 56) begin
				send_item(FUNC_WRITE, latch_cmd(REG_NOISE, 4'($urandom)));
				sent++;
			end else if (pick < 61) begin
				send_item(FUNC_WRITE, data_cmd(1'($urandom), 6'($urandom)));
				sent++;
			end else if (pick < 93) begin
				reps = $urandom_range(1, 6);
				repeat (reps) begin
					send_item(FUNC_TICK, 8'($urandom));
					sent++;
				end
			end else begin
				send_item(1'($urandom), 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		logic [16:0] rate_plan [6];
		sb = new();
		rate_plan[0] = RATE_MIN;
		rate_plan[1] = RATE_MAX;
		rate_plan[2] = RATE_OFF;
		rate_plan[3] = RATE_FULL;
		rate_plan[4] = 17'($urandom_range(RATE_MIN, RATE_MAX));
		rate_plan[5] = SAMPLE_RATE_RESET;

		// Hold reset, then release it on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening at the reset sample rate. Silence first, then the
		// largest divider at full volume, the smallest divider muted and
		// unmuted, a zero divider that keeps its voice off, noise synced to a
		// zero tone 2 (stays off), tone 2 then written so the sync period
		// follows, and the noise modes through latch and data bytes.
		send_item(FUNC_TICK, '0);
		send_item(FUNC_WRITE, latch_cmd(REG_TONE0, 4'hF));
		send_item(FUNC_WRITE, data_cmd(1'b1, 6'h3F));
		send_item(FUNC_WRITE, latch_cmd(REG_ATT0, ATT_LOUDEST));
		send_item(FUNC_TICK, 8'hFF);
		send_item(FUNC_WRITE, latch_cmd(REG_TONE1, 4'h1));
		send_item(FUNC_WRITE, data_cmd(1'b0, 6'h00));
		send_item(FUNC_WRITE, latch_cmd(REG_ATT1, ATT_MUTE));
		send_item(FUNC_TICK, '0);
		send_item(FUNC_WRITE, latch_cmd(REG_ATT1, 4'hE));
		send_item(FUNC_TICK, '0);
		send_item(FUNC_WRITE, latch_cmd(REG_TONE2, 4'h0));
		send_item(FUNC_WRITE, data_cmd(1'b0, 6'h00));
		send_item(FUNC_WRITE, latch_cmd(REG_ATT2, 4'h7));
		send_item(FUNC_WRITE, latch_cmd(REG_NOISE, {2'b01, NOISE_SYNC}));
		send_item(FUNC_WRITE, latch_cmd(REG_ATT3, ATT_LOUDEST));
		send_item(FUNC_WRITE, latch_cmd(REG_TONE2, 4'h8));
		send_item(FUNC_TICK, '0);
		send_item(FUNC_WRITE, data_cmd(1'b0, 6'h2A));
		send_item(FUNC_WRITE, latch_cmd(REG_ATT3, 4'h3));
		send_item(FUNC_TICK, '0);
		send_item(FUNC_WRITE, latch_cmd(REG_NOISE, 4'h4));
		send_item(FUNC_TICK, '0);
		send_item(FUNC_WRITE, data_cmd(1'b1, 6'h31));
		send_item(FUNC_TICK, '0);
		send_item(FUNC_TICK, '0);

		// Random phases, each at its own sample rate: both ends of the usual
		// range, zero (every period computed then stays zero and its voice
		// holds), the full 17-bit value, a random rate and back to the reset
		// rate. Each change waits for the core to drain.
		foreach (rate_plan[i]) begin
			set_rate(rate_plan[i]);
			random_mix(285);
		end

		drain();
		$display("Run covered %0d command bytes and %0d samples (%0d checked) over %0d rates.",
			sb.n_cmds, sb.n_samples, samples_seen, rates_used);
		if (sb.n_errors == 0)
			$display("PASS psg_tone_noise_synth_core");
		else
			$display("FAIL psg_tone_noise_synth_core");
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#30_000_000;
		$display("FAIL psg_tone_noise_synth_core");
		$finish;
	end

endmodule
